[rtl/nmb_pkg.sv]
`default_nettype none

package nmb_pkg;

	// Default build limits of the image.
	localparam int MAX_COLS_DEF = 64;
	localparam int MAX_ROWS_DEF = 1024;

	// Both image dimensions come out of reset at this value, clamped to the build limits.
	localparam int RESET_DIM = 64;

	// Fixed field widths.
	localparam int PIX_W      = 16;
	localparam int ROW_OUT_W  = 10;
	localparam int COL_OUT_W  = 6;
	localparam int ROWS_CFG_W = 11;
	localparam int COLS_CFG_W = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	// One line buffer word holds the two rows above the incoming pixel.
	localparam int LINE_W = 2 * PIX_W;

	// Eight 16-bit neighbors sum to at most 19 bits; the count is at most eight.
	localparam int SUM_W = 19;
	localparam int CNT_W = 4;

	// Division by three and five as a multiply by a rounded-up reciprocal.
	localparam int RECIP_W     = 20;
	localparam int RECIP_SHIFT = 21;
	localparam logic [RECIP_W-1:0] RECIP_3 = 20'd699051;
	localparam logic [RECIP_W-1:0] RECIP_5 = 20'd419431;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 2'd1;

	// Results one pixel can release, in output order (bit positions of the pending mask).
	localparam int N_KINDS         = 4;
	localparam int KIND_ABOVE_LEFT = 0;
	localparam int KIND_ABOVE_HERE = 1;
	localparam int KIND_HERE_LEFT  = 2;
	localparam int KIND_HERE_HERE  = 3;

	// Where the accepted pixel sits in the image.
	typedef struct packed {
		logic row_ge1;
		logic row_ge2;
		logic row_last;
		logic col_ge1;
		logic col_ge2;
		logic col_last;
	} pos_flags_t;

	// One image column of the 3x3 window, top to bottom.
	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
	} column_t;

	// Work handed from the window stage to the divider.
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] cnt;
		logic             frame_done;
		logic             last_of_run;
	} mean_job_t;

endpackage

`default_nettype wire

[rtl/nmb_cfg_if.sv]
`default_nettype none

interface nmb_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [nmb_pkg::CFG_IDX_W-1:0]  index;
	logic [nmb_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/nmb_pix_if.sv]
`default_nettype none

interface nmb_pix_if;
	logic                      valid;
	logic                      ready;
	logic [nmb_pkg::PIX_W-1:0] pixel;

	modport source(output valid, output pixel, input ready);
	modport sink(input valid, input pixel, output ready);
endinterface

`default_nettype wire

[rtl/nmb_res_if.sv]
`default_nettype none

interface nmb_res_if;
	logic                          valid;
	logic                          ready;
	logic [nmb_pkg::ROW_OUT_W-1:0] out_row;
	logic [nmb_pkg::COL_OUT_W-1:0] out_col;
	logic [nmb_pkg::PIX_W-1:0]     mean_value;
	logic                          frame_done;
	logic                          last_of_run;

	modport source(output valid, output out_row, output out_col, output mean_value,
		output frame_done, output last_of_run, input ready);
	modport sink(input valid, input out_row, input out_col, input mean_value,
		input frame_done, input last_of_run, output ready);
endinterface

`default_nettype wire

[rtl/nmb_ram.sv]
`default_nettype none

module nmb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port; a read at the written address sees old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/nmb_window.sv]
`default_nettype none

module nmb_window #(
	parameter int RW = 10,
	parameter int CW = 6
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [nmb_pkg::PIX_W-1:0]    in_pixel,
	input  wire logic [RW-1:0]                in_row,
	input  wire logic [CW-1:0]                in_col,
	input  wire nmb_pkg::pos_flags_t          in_flags,
	input  wire logic [nmb_pkg::LINE_W-1:0]   ram_rdata,
	output logic                              ram_we,
	output logic      [CW-1:0]                ram_waddr,
	output logic      [nmb_pkg::LINE_W-1:0]   ram_wdata,
	output logic                              job_valid,
	input  wire logic                         job_ready,
	output nmb_pkg::mean_job_t                job,
	output logic      [RW-1:0]                job_row,
	output logic      [CW-1:0]                job_col
);

	localparam int NK = nmb_pkg::N_KINDS;
	localparam int PW = nmb_pkg::PIX_W;

	// Stage one: the accepted pixel, its line buffer word and its pending results.
	logic                       valid_s1;
	logic [PW-1:0]              pix_s1;
	logic [RW-1:0]              row_s1;
	logic [CW-1:0]              col_s1;
	nmb_pkg::pos_flags_t        flags_s1;
	logic [NK-1:0]              rem_s1;
	logic                       fwd_s1;
	logic [nmb_pkg::LINE_W-1:0] fwd_word_s1;

	// The two columns left of the current one.
	nmb_pkg::column_t w1_q;
	nmb_pkg::column_t w2_q;

	// Stage two: sum and count of one result.
	logic               valid_s2;
	nmb_pkg::mean_job_t job_s2;
	logic [RW-1:0]      row_s2;
	logic [CW-1:0]      col_s2;

	logic                       accept;
	logic                       s2_free;
	logic                       rem_single;
	logic                       emit;
	logic                       s1_leave;
	logic [NK-1:0]              pick;
	logic [NK-1:0]              rem_in;
	logic [nmb_pkg::LINE_W-1:0] word;
	logic [nmb_pkg::LINE_W-1:0] wr_word;
	nmb_pkg::column_t           cur_col;
	logic                       row_here;
	logic                       col_here;
	nmb_pkg::column_t           left_c;
	nmb_pkg::column_t           ctr_c;
	nmb_pkg::column_t           right_c;
	logic                       left_v;
	logic                       right_v;
	logic                       up_v;
	logic                       dn_v;
	logic [PW-1:0]              nb_val [8];
	logic [7:0]                 nb_v;
	logic [nmb_pkg::SUM_W-1:0]  sum;
	logic [nmb_pkg::CNT_W-1:0]  cnt;

	// Move a column up by one row when the result's center is the current row.
	function automatic nmb_pkg::column_t rows_of(nmb_pkg::column_t c, logic here);
		nmb_pkg::column_t r;
		if (here) begin
			r.top = c.mid;
			r.mid = c.bot;
			r.bot = '0;
		end else begin
			r = c;
		end
		return r;
	endfunction

	// Handshake between the stages.
	assign s2_free    = !valid_s2 || job_ready;
	assign rem_single = ((rem_s1 & (rem_s1 - NK'(1))) == '0);
	assign emit       = valid_s1 && (rem_s1 != '0) && s2_free;
	assign s1_leave   = valid_s1 && ((rem_s1 == '0) || (emit && rem_single));
	assign in_ready   = !valid_s1 || s1_leave;
	assign accept     = in_valid && in_ready;
	assign pick       = rem_s1 & (~rem_s1 + NK'(1));

	// Results the incoming pixel releases.
	always_comb begin
		rem_in = '0;
		rem_in[nmb_pkg::KIND_ABOVE_LEFT] = in_flags.row_ge1 && in_flags.col_ge1;
		rem_in[nmb_pkg::KIND_ABOVE_HERE] = in_flags.row_ge1 && in_flags.col_last;
		rem_in[nmb_pkg::KIND_HERE_LEFT]  = in_flags.row_last && in_flags.col_ge1;
		rem_in[nmb_pkg::KIND_HERE_HERE]  = in_flags.row_last && in_flags.col_last;
	end

	// Current column; a write to the same column in the accept cycle is forwarded.
	assign word      = fwd_s1 ? fwd_word_s1 : ram_rdata;
	assign cur_col   = '{top: word[PW-1:0], mid: word[2*PW-1:PW], bot: pix_s1};
	assign wr_word   = {pix_s1, word[2*PW-1:PW]};
	assign ram_we    = s1_leave;
	assign ram_waddr = col_s1;
	assign ram_wdata = wr_word;

	// Window geometry of the result picked this cycle.
	assign row_here = pick[nmb_pkg::KIND_HERE_LEFT] || pick[nmb_pkg::KIND_HERE_HERE];
	assign col_here = pick[nmb_pkg::KIND_ABOVE_HERE] || pick[nmb_pkg::KIND_HERE_HERE];

	always_comb begin
		if (col_here) begin
			left_c  = rows_of(w1_q, row_here);
			ctr_c   = rows_of(cur_col, row_here);
			right_c = rows_of(cur_col, row_here);
			left_v  = flags_s1.col_ge1;
			right_v = 1'b0;
		end else begin
			left_c  = rows_of(w2_q, row_here);
			ctr_c   = rows_of(w1_q, row_here);
			right_c = rows_of(cur_col, row_here);
			left_v  = flags_s1.col_ge2;
			right_v = 1'b1;
		end
		up_v = row_here ? flags_s1.row_ge1 : flags_s1.row_ge2;
		dn_v = !row_here;
	end

	// The eight neighbors, center excluded.
	always_comb begin
		nb_val[0] = left_c.top;
		nb_val[1] = left_c.mid;
		nb_val[2] = left_c.bot;
		nb_val[3] = ctr_c.top;
		nb_val[4] = ctr_c.bot;
		nb_val[5] = right_c.top;
		nb_val[6] = right_c.mid;
		nb_val[7] = right_c.bot;
		nb_v[0]   = left_v && up_v;
		nb_v[1]   = left_v;
		nb_v[2]   = left_v && dn_v;
		nb_v[3]   = up_v;
		nb_v[4]   = dn_v;
		nb_v[5]   = right_v && up_v;
		nb_v[6]   = right_v;
		nb_v[7]   = right_v && dn_v;
	end

	// Sum and count of the neighbors inside the image.
	always_comb begin
		sum = '0;
		cnt = '0;
		for (int k = 0; k < 8; k++) begin
			sum = sum + (nb_v[k] ? nmb_pkg::SUM_W'(nb_val[k]) : '0);
			cnt = cnt + nmb_pkg::CNT_W'(nb_v[k]);
		end
	end

	// Stage one control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rem_s1   <= '0;
			fwd_s1   <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				rem_s1   <= rem_in;
				fwd_s1   <= s1_leave && (in_col == col_s1);
			end else begin
				if (s1_leave) begin
					valid_s1 <= 1'b0;
				end
				if (emit) begin
					rem_s1 <= rem_s1 & ~pick;
				end
			end
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= in_pixel;
			row_s1      <= in_row;
			col_s1      <= in_col;
			flags_s1    <= in_flags;
			fwd_word_s1 <= wr_word;
		end
		if (s1_leave) begin
			w2_q <= w1_q;
			w1_q <= cur_col;
		end
	end

	// Stage two control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			if (emit) begin
				valid_s2 <= 1'b1;
			end else if (job_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Stage two payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			job_s2.sum         <= sum;
			job_s2.cnt         <= cnt;
			job_s2.frame_done  <= rem_single && flags_s1.row_last && flags_s1.col_last;
			job_s2.last_of_run <= rem_single;
			row_s2             <= row_here ? row_s1 : row_s1 - RW'(1);
			col_s2             <= col_here ? col_s1 : col_s1 - CW'(1);
		end
	end

	assign job_valid = valid_s2;
	assign job       = job_s2;
	assign job_row   = row_s2;
	assign job_col   = col_s2;

endmodule

`default_nettype wire

[rtl/nmb_divide.sv]
`default_nettype none

module nmb_divide #(
	parameter int RW = 10,
	parameter int CW = 6
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               job_valid,
	output logic                    job_ready,
	input  wire nmb_pkg::mean_job_t job,
	input  wire logic [RW-1:0]      job_row,
	input  wire logic [CW-1:0]      job_col,
	nmb_res_if.source               results
);

	localparam int SW     = nmb_pkg::SUM_W;
	localparam int NW     = nmb_pkg::CNT_W;
	localparam int PROD_W = nmb_pkg::SUM_W + nmb_pkg::RECIP_W;

	logic                                valid_s3;
	logic [nmb_pkg::ROW_OUT_W-1:0]       row_s3;
	logic [nmb_pkg::COL_OUT_W-1:0]       col_s3;
	logic [nmb_pkg::PIX_W-1:0]           mean_s3;
	logic                                done_s3;
	logic                                last_s3;

	logic [nmb_pkg::RECIP_W-1:0] recip;
	logic [PROD_W-1:0]           prod;
	logic [SW-1:0]               quot;
	logic                        take;

	assign job_ready = !valid_s3 || results.ready;
	assign take      = job_valid && job_ready;

	// Divide by the neighbor count: shifts for one, two and eight, a reciprocal for three and five.
	always_comb begin
		unique case (job.cnt)
			NW'(3):  recip = nmb_pkg::RECIP_3;
			NW'(5):  recip = nmb_pkg::RECIP_5;
			default: recip = '0;
		endcase
		prod = PROD_W'(job.sum) * PROD_W'(recip);
		unique case (job.cnt)
			NW'(1):         quot = job.sum;
			NW'(2):         quot = job.sum >> 1;
			NW'(3), NW'(5): quot = SW'(prod >> nmb_pkg::RECIP_SHIFT);
			NW'(8):         quot = job.sum >> 3;
			default:        quot = '0;
		endcase
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			if (take) begin
				valid_s3 <= 1'b1;
			end else if (results.ready) begin
				valid_s3 <= 1'b0;
			end
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (take) begin
			row_s3  <= nmb_pkg::ROW_OUT_W'(job_row);
			col_s3  <= nmb_pkg::COL_OUT_W'(job_col);
			mean_s3 <= nmb_pkg::PIX_W'(quot);
			done_s3 <= job.frame_done;
			last_s3 <= job.last_of_run;
		end
	end

	assign results.valid       = valid_s3;
	assign results.out_row     = row_s3;
	assign results.out_col     = col_s3;
	assign results.mean_value  = mean_s3;
	assign results.frame_done  = done_s3;
	assign results.last_of_run = last_s3;

endmodule

`default_nettype wire

[rtl/neighbor_mean_blur_3x3_unit.sv]
`default_nettype none

// Streaming 3x3 neighbor-mean blur. Pixels enter in raster order, one beat per pixel, and each
// result beat carries the row, column and truncated mean of the in-image neighbors of one
// position, center excluded. A result leaves as soon as its lower-right neighbor has arrived.
// A pixel is taken every cycle while the output does not stall, except that a pixel that
// releases several results holds the input until the window stage has issued the last one: a
// pixel at the end of a row or in the last row releases at most two results, and the last pixel
// of the frame four; the result sequencer in the window stage issues them in turn. A result is
// registered in the window sum register, then divided into the output register, and further
// results of the same pixel follow one per cycle while the output does not stall. The line
// buffer is one memory of MAX_COLS words holding the two rows above, read and written once per
// pixel; it needs no clearing pass. Writing either size register restarts the frame at row 0,
// column 0; a zero size counts as one and a size above the build limit counts as the limit. The
// user must write size registers only while the block is idle; the block does not enforce it.
module neighbor_mean_blur_3x3_unit #(
	parameter int MAX_COLS = nmb_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = nmb_pkg::MAX_ROWS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	nmb_cfg_if.sink   cfg,
	nmb_pix_if.sink   pixels,
	nmb_res_if.source results
);

	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS);
	localparam int RESET_ROWS = (nmb_pkg::RESET_DIM > MAX_ROWS) ? MAX_ROWS : nmb_pkg::RESET_DIM;
	localparam int RESET_COLS = (nmb_pkg::RESET_DIM > MAX_COLS) ? MAX_COLS : nmb_pkg::RESET_DIM;

	logic [RW-1:0] rows_last_q;
	logic [CW-1:0] cols_last_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;

	logic                            cfg_wr;
	logic [nmb_pkg::ROWS_CFG_W-1:0]  rows_val;
	logic [nmb_pkg::COLS_CFG_W-1:0]  cols_val;
	logic [RW-1:0]                   rows_wr_last;
	logic [CW-1:0]                   cols_wr_last;
	logic                            in_acc;
	logic                            win_ready;
	nmb_pkg::pos_flags_t             flags;

	logic                       ram_we;
	logic [CW-1:0]              ram_waddr;
	logic [nmb_pkg::LINE_W-1:0] ram_wdata;
	logic [nmb_pkg::LINE_W-1:0] ram_rdata;

	logic               job_valid;
	logic               job_ready;
	nmb_pkg::mean_job_t job;
	logic [RW-1:0]      job_row;
	logic [CW-1:0]      job_col;

	// Configuration writes are always taken.
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid;
	assign rows_val  = cfg.data[nmb_pkg::ROWS_CFG_W-1:0];
	assign cols_val  = cfg.data[nmb_pkg::COLS_CFG_W-1:0];

	// Clamp a written size and keep it as the index of the last row or column.
	always_comb begin
		priority if (rows_val == '0) begin
			rows_wr_last = '0;
		end else if (32'(rows_val) > MAX_ROWS) begin
			rows_wr_last = RW'(MAX_ROWS - 1);
		end else begin
			rows_wr_last = RW'(rows_val - 1'b1);
		end
		priority if (cols_val == '0) begin
			cols_wr_last = '0;
		end else if (32'(cols_val) > MAX_COLS) begin
			cols_wr_last = CW'(MAX_COLS - 1);
		end else begin
			cols_wr_last = CW'(cols_val - 1'b1);
		end
	end

	assign pixels.ready = win_ready;
	assign in_acc       = pixels.valid && pixels.ready;

	// Size registers and the position of the next pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_last_q <= RW'(RESET_ROWS - 1);
			cols_last_q <= CW'(RESET_COLS - 1);
			row_q       <= '0;
			col_q       <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg.index)
					nmb_pkg::REG_IMAGE_ROWS: begin
						rows_last_q <= rows_wr_last;
						row_q       <= '0;
						col_q       <= '0;
					end
					nmb_pkg::REG_IMAGE_COLS: begin
						cols_last_q <= cols_wr_last;
						row_q       <= '0;
						col_q       <= '0;
					end
					default: begin
					end
				endcase
			end else if (in_acc) begin
				if (col_q == cols_last_q) begin
					col_q <= '0;
					row_q <= (row_q == rows_last_q) ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	// Position of the incoming pixel relative to the image borders.
	always_comb begin
		flags.row_ge1  = (row_q != '0);
		flags.row_ge2  = (row_q > RW'(1));
		flags.row_last = (row_q == rows_last_q);
		flags.col_ge1  = (col_q != '0);
		flags.col_ge2  = (col_q > CW'(1));
		flags.col_last = (col_q == cols_last_q);
	end

	// Line buffer: per column, the pixels of the two rows above.
	nmb_ram #(
		.WIDTH(nmb_pkg::LINE_W),
		.DEPTH(MAX_COLS)
	) u_line (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (in_acc),
		.raddr(col_q),
		.rdata(ram_rdata)
	);

	nmb_window #(
		.RW(RW),
		.CW(CW)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixels.valid),
		.in_ready (win_ready),
		.in_pixel (pixels.pixel),
		.in_row   (row_q),
		.in_col   (col_q),
		.in_flags (flags),
		.ram_rdata(ram_rdata),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job      (job),
		.job_row  (job_row),
		.job_col  (job_col)
	);

	nmb_divide #(
		.RW(RW),
		.CW(CW)
	) u_divide (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job      (job),
		.job_row  (job_row),
		.job_col  (job_col),
		.results  (results)
	);

`ifndef NO_ASSERTIONS
	// A size write restarts the frame.
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid && cfg.ready
		&& (cfg.index == nmb_pkg::REG_IMAGE_ROWS || cfg.index == nmb_pkg::REG_IMAGE_COLS)
		|=> row_q == '0 && col_q == '0)
		else $error("frame position not cleared after a size write");

	// The next pixel position always lies inside the configured image.
	a_pos_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= rows_last_q && col_q <= cols_last_q)
		else $error("pixel position outside the image");

	// The end of a frame is also the end of the run released by its last pixel.
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.frame_done |-> results.last_of_run)
		else $error("frame end flagged on a result that is not last of its run");
`endif

endmodule

`default_nettype wire
